// ===== hw/rtl/tppg_pkg.sv =====
// Shared constants, font tables and helper functions of the status panel pixel generator.
`default_nettype none

package tppg_pkg;

  // Display and font geometry
  localparam int DISPLAY_WIDTH  = 800;
  localparam int DISPLAY_HEIGHT = 480;
  localparam int DOT_SCALE      = 4;
  localparam int DOT_COLS       = 5;
  localparam int CELL_ADVANCE   = 24;
  localparam int LINE_HEIGHT    = 28;
  localparam int LINE_PITCH     = 44;
  localparam int NUM_LINES      = 5;
  localparam int PANEL_MARGIN   = 16;
  localparam int MAX_CHARS      = 16;
  localparam int BLOCK_WIDTH    = MAX_CHARS * CELL_ADVANCE - DOT_SCALE;
  localparam int BLOCK_HEIGHT   = NUM_LINES * LINE_HEIGHT + (NUM_LINES - 1) * LINE_PITCH;
  localparam int TEXT_ROWS      = NUM_LINES * LINE_PITCH;

  localparam int X0 = (DISPLAY_WIDTH - BLOCK_WIDTH) / 2;
  localparam int Y0 = (DISPLAY_HEIGHT - BLOCK_HEIGHT) / 2;
  localparam int PANEL_X_LO = X0 - PANEL_MARGIN;
  localparam int PANEL_X_HI = X0 + BLOCK_WIDTH + PANEL_MARGIN;
  localparam int PANEL_Y_LO = Y0 - PANEL_MARGIN;
  localparam int PANEL_Y_HI = Y0 + BLOCK_HEIGHT + PANEL_MARGIN;

  // Character counts per line kind and the resulting centered start columns
  localparam int LEN_LONG    = 16;
  localparam int LEN_BOARD   = 12;
  localparam int LEN_TOUCH   = 6;
  localparam int LEN_NOTOUCH = 4;
  localparam int LX_LONG    = (DISPLAY_WIDTH - (LEN_LONG * CELL_ADVANCE - DOT_SCALE)) / 2;
  localparam int LX_BOARD   = (DISPLAY_WIDTH - (LEN_BOARD * CELL_ADVANCE - DOT_SCALE)) / 2;
  localparam int LX_TOUCH   = (DISPLAY_WIDTH - (LEN_TOUCH * CELL_ADVANCE - DOT_SCALE)) / 2;
  localparam int LX_NOTOUCH = (DISPLAY_WIDTH - (LEN_NOTOUCH * CELL_ADVANCE - DOT_SCALE)) / 2;

  // Line numbers
  localparam logic [2:0] LINE_TITLE  = 3'd0;
  localparam logic [2:0] LINE_BOARD  = 3'd1;
  localparam logic [2:0] LINE_UPTIME = 3'd2;
  localparam logic [2:0] LINE_TX     = 3'd3;
  localparam logic [2:0] LINE_TY     = 3'd4;

  // Decimal conversion constants
  localparam int          UPTIME_MOD  = 1000000;
  localparam int          TOUCH_MOD   = 10000;
  localparam int          RECIP_SHIFT = 50;
  localparam int          UQ_W        = 13;
  localparam logic [63:0] UPTIME_RECIP = (64'd1 << RECIP_SHIFT) / 64'(UPTIME_MOD);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BACKGROUND = 2'd0,
    CFG_PANEL      = 2'd1,
    CFG_TEXT       = 2'd2,
    CFG_ACCENT     = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] RST_BACKGROUND = 16'd4294;
  localparam logic [15:0] RST_PANEL      = 16'd0;
  localparam logic [15:0] RST_TEXT       = 16'd65535;
  localparam logic [15:0] RST_ACCENT     = 16'd18015;

  // Glyph codes (digits 0..9 use their own value)
  localparam int NUM_GLYPHS = 33;
  localparam logic [5:0] G_SPACE = 6'd10;
  localparam logic [5:0] G_H     = 6'd11;
  localparam logic [5:0] G_L     = 6'd12;
  localparam logic [5:0] G_M     = 6'd13;
  localparam logic [5:0] G_C     = 6'd14;
  localparam logic [5:0] G_E     = 6'd15;
  localparam logic [5:0] G_I     = 6'd16;
  localparam logic [5:0] G_K     = 6'd17;
  localparam logic [5:0] G_LL    = 6'd18;
  localparam logic [5:0] G_MM    = 6'd19;
  localparam logic [5:0] G_N     = 6'd20;
  localparam logic [5:0] G_O     = 6'd21;
  localparam logic [5:0] G_P     = 6'd22;
  localparam logic [5:0] G_R     = 6'd23;
  localparam logic [5:0] G_S     = 6'd24;
  localparam logic [5:0] G_T     = 6'd25;
  localparam logic [5:0] G_U     = 6'd26;
  localparam logic [5:0] G_X     = 6'd27;
  localparam logic [5:0] G_Y     = 6'd28;
  localparam logic [5:0] G_DASH  = 6'd29;
  localparam logic [5:0] G_COLON = 6'd30;
  localparam logic [5:0] G_BANG  = 6'd31;
  localparam logic [5:0] G_EQ    = 6'd32;

  // 5x7 font, one byte per dot column, bit n is dot row n
  localparam logic [7:0] GLYPH_ROM [NUM_GLYPHS][DOT_COLS] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h20}, '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18},
    '{8'h00, 8'h44, 8'h7D, 8'h40, 8'h00}, '{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00},
    '{8'h00, 8'h41, 8'h7F, 8'h40, 8'h00}, '{8'h7C, 8'h04, 8'h18, 8'h04, 8'h78},
    '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h78}, '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38},
    '{8'hFC, 8'h24, 8'h24, 8'h24, 8'h18}, '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08},
    '{8'h48, 8'h54, 8'h54, 8'h54, 8'h24}, '{8'h04, 8'h3F, 8'h44, 8'h40, 8'h20},
    '{8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C}, '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
    '{8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
    '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
    '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14}
  };

  // Fixed banner strings
  localparam logic [5:0] TITLE_STR [16] = '{
    G_U, G_LL, G_MM, G_K, G_SPACE, G_M, G_I, G_C,
    G_R, G_O, G_K, G_E, G_R, G_N, G_E, G_LL
  };
  localparam logic [5:0] BOARD_STR [12] = '{
    G_H, G_E, G_LL, G_LL, G_O, G_SPACE, G_L, G_I, G_N, G_U, G_MM, G_BANG
  };
  localparam logic [5:0] PREFIX_STR [8] = '{
    G_U, G_P, G_T, G_I, G_MM, G_E, G_COLON, G_SPACE
  };

  // One decimal digit step: digit = v / unit and the remainder, for v < 10 * unit
  function automatic logic [23:0] dec_step(input logic [19:0] v, input logic [19:0] unit);
    logic [3:0]  d;
    logic [19:0] sub;
    d   = '0;
    sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 20'(k) * unit) begin
        d   = 4'(k);
        sub = 20'(k) * unit;
      end
    end
    return {d, v - sub};
  endfunction

  // Start column of a line
  function automatic logic [11:0] line_start(input logic [2:0] line, input logic tv);
    logic [11:0] lx;
    case (line)
      LINE_TITLE, LINE_UPTIME: lx = 12'(LX_LONG);
      LINE_BOARD:              lx = 12'(LX_BOARD);
      default:                 lx = tv ? 12'(LX_TOUCH) : 12'(LX_NOTOUCH);
    endcase
    return lx;
  endfunction

  // Pixel width of a line (characters times advance)
  function automatic logic [11:0] line_span(input logic [2:0] line, input logic tv);
    logic [11:0] sp;
    case (line)
      LINE_TITLE, LINE_UPTIME: sp = 12'(LEN_LONG * CELL_ADVANCE);
      LINE_BOARD:              sp = 12'(LEN_BOARD * CELL_ADVANCE);
      default:                 sp = tv ? 12'(LEN_TOUCH * CELL_ADVANCE)
                                       : 12'(LEN_NOTOUCH * CELL_ADVANCE);
    endcase
    return sp;
  endfunction

  // Glyph code of character ci on a line; ud, txd, tyd hold digits, most significant highest
  function automatic logic [5:0] cell_code(input logic [2:0] line, input logic [3:0] ci,
                                           input logic tv, input logic [5:0][3:0] ud,
                                           input logic [3:0][3:0] txd,
                                           input logic [3:0][3:0] tyd);
    logic [5:0] c;
    logic [3:0] ui;
    logic [3:0] ti;
    ui = 4'd13 - ci;
    ti = 4'd5 - ci;
    c  = G_SPACE;
    case (line)
      LINE_TITLE: c = TITLE_STR[ci];
      LINE_BOARD: begin
        if (ci < 4'(LEN_BOARD)) c = BOARD_STR[ci];
      end
      LINE_UPTIME: begin
        if (ci < 4'd8)       c = PREFIX_STR[ci[2:0]];
        else if (ci < 4'd14) c = {2'b00, ud[ui[2:0]]};
        else if (ci == 4'd15) c = G_S;
      end
      default: begin
        if (ci == 4'd0)      c = (line == LINE_TX) ? G_X : G_Y;
        else if (ci == 4'd1) c = G_EQ;
        else if (!tv)        c = G_DASH;
        else if (line == LINE_TX) c = {2'b00, txd[ti[1:0]]};
        else                 c = {2'b00, tyd[ti[1:0]]};
      end
    endcase
    return c;
  endfunction

  // Dot of the font at a column and row
  function automatic logic glyph_dot(input logic [5:0] code, input logic [2:0] col,
                                     input logic [2:0] row);
    logic [7:0] bits;
    bits = '0;
    if (code < 6'(NUM_GLYPHS) && col < 3'(DOT_COLS)) bits = GLYPH_ROM[code][col];
    return bits[row];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/text_panel_pixel_generator_unit.sv =====
// Status panel pixel generator: nine-stage pixel pipeline plus output register.
// Throughput: one pixel per cycle while the output is not stalled; the depth is set by the uptime decimal path
// (reciprocal multiply, remainder multiply, then one digit per stage).
// A stall at the output fills empty stages first; input stalls only when all are full.
// Reset clears all valid bits and loads the reset colors into the four color registers.
`default_nettype none

module text_panel_pixel_generator_unit import tppg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // pixel request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [9:0]  pixel_x_i,
  input  wire logic [8:0]  pixel_y_i,
  input  wire logic [31:0] uptime_sec_i,
  input  wire logic        touch_valid_i,
  input  wire logic [15:0] touch_x_i,
  input  wire logic [15:0] touch_y_i,
  // pixel color channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      pixel_color_o
);

  localparam int NST = 9;

  typedef struct packed {
    logic [9:0]       x;
    logic             in_panel;
    logic             in_text;
    logic [7:0]       dy;
    logic [2:0]       line;
    logic [5:0]       r;
    logic             line_on;
    logic [8:0]       dx;
    logic             in_line;
    logic [3:0]       ci;
    logic [4:0]       cx;
    logic [2:0]       col;
    logic [2:0]       row;
    logic             dot_ok;
    logic [UQ_W-1:0]  uq;
    logic [20:0]      ulo;
    logic [20:0]      uqm;
    logic [19:0]      urem;
    logic [5:0][3:0]  ud;
    logic             tv;
    logic [13:0]      txr;
    logic [13:0]      tyr;
    logic [3:0][3:0]  txd;
    logic [3:0][3:0]  tyd;
    logic [5:0]       code;
  } pix_t;

  // Color registers
  logic [15:0] bg_q, panel_q, text_q, accent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q     <= RST_BACKGROUND;
      panel_q  <= RST_PANEL;
      text_q   <= RST_TEXT;
      accent_q <= RST_ACCENT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BACKGROUND: bg_q     <= cfg_wdata_i;
        CFG_PANEL:      panel_q  <= cfg_wdata_i;
        CFG_TEXT:       text_q   <= cfg_wdata_i;
        CFG_ACCENT:     accent_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage flow control: a stage takes new data when empty or when its successor moves
  logic [NST:0] v_q;
  logic [NST:0] rdy;

  always_comb begin
    rdy[NST] = !v_q[NST] || !out_stall_i;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i <= NST; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // Stage logic
  pix_t        s_q [NST];
  pix_t        s_d [NST];
  logic [15:0] color_q;
  logic [15:0] color_d;

  always_comb begin
    logic [63:0] prod;
    logic [33:0] qm;
    logic [23:0] st;
    logic [23:0] st2;
    logic [7:0]  lbase;
    logic [8:0]  cbase;
    logic [20:0] diff;
    logic [11:0] lx;
    logic [12:0] lend;
    logic        dot;

    // Stage 0: panel test, row offset, reciprocal multiply, touch modulo
    s_d[0]          = '0;
    s_d[0].x        = pixel_x_i;
    s_d[0].in_panel = (32'(pixel_x_i) >= PANEL_X_LO) && (32'(pixel_x_i) < PANEL_X_HI) &&
                      (32'(pixel_y_i) >= PANEL_Y_LO) && (32'(pixel_y_i) < PANEL_Y_HI);
    s_d[0].in_text  = (32'(pixel_y_i) >= Y0) && (32'(pixel_y_i) < Y0 + TEXT_ROWS);
    s_d[0].dy       = 8'(32'(pixel_y_i) - 32'(Y0));
    prod            = 64'(uptime_sec_i) * UPTIME_RECIP;
    s_d[0].uq       = prod[RECIP_SHIFT +: UQ_W];
    s_d[0].ulo      = uptime_sec_i[20:0];
    s_d[0].tv       = touch_valid_i;
    st              = dec_step(20'(touch_x_i), 20'(TOUCH_MOD));
    s_d[0].txr      = st[13:0];
    st2             = dec_step(20'(touch_y_i), 20'(TOUCH_MOD));
    s_d[0].tyr      = st2[13:0];

    // Stage 1: line number and row in line, quotient times modulus, touch thousands
    s_d[1]      = s_q[0];
    s_d[1].line = '0;
    lbase       = '0;
    for (int j = 1; j < NUM_LINES; j++) begin
      if (s_q[0].dy >= 8'(j * LINE_PITCH)) begin
        s_d[1].line = 3'(j);
        lbase       = 8'(j * LINE_PITCH);
      end
    end
    s_d[1].r       = 6'(s_q[0].dy - lbase);
    s_d[1].line_on = s_q[0].in_text && (6'(s_q[0].dy - lbase) < 6'(LINE_HEIGHT));
    qm             = 34'(s_q[0].uq) * 34'(UPTIME_MOD);
    s_d[1].uqm     = qm[20:0];
    st             = dec_step(20'(s_q[0].txr), 20'd1000);
    s_d[1].txd[3]  = st[23:20];
    s_d[1].txr     = st[13:0];
    st2            = dec_step(20'(s_q[0].tyr), 20'd1000);
    s_d[1].tyd[3]  = st2[23:20];
    s_d[1].tyr     = st2[13:0];

    // Stage 2: uptime modulo one million, column offset in line, touch hundreds
    s_d[2]         = s_q[1];
    diff           = s_q[1].ulo - s_q[1].uqm;
    s_d[2].urem    = (diff >= 21'(UPTIME_MOD)) ? 20'(diff - 21'(UPTIME_MOD)) : diff[19:0];
    lx             = line_start(s_q[1].line, s_q[1].tv);
    lend           = 13'(lx) + 13'(line_span(s_q[1].line, s_q[1].tv));
    s_d[2].in_line = s_q[1].line_on && (12'(s_q[1].x) >= lx) && (13'(s_q[1].x) < lend);
    s_d[2].dx      = 9'(12'(s_q[1].x) - lx);
    st             = dec_step(20'(s_q[1].txr), 20'd100);
    s_d[2].txd[2]  = st[23:20];
    s_d[2].txr     = st[13:0];
    st2            = dec_step(20'(s_q[1].tyr), 20'd100);
    s_d[2].tyd[2]  = st2[23:20];
    s_d[2].tyr     = st2[13:0];

    // Stage 3: uptime hundred-thousands, character index, touch tens and ones
    s_d[3]        = s_q[2];
    st            = dec_step(s_q[2].urem, 20'd100000);
    s_d[3].ud[5]  = st[23:20];
    s_d[3].urem   = st[19:0];
    s_d[3].ci     = '0;
    cbase         = '0;
    for (int j = 1; j < MAX_CHARS; j++) begin
      if (s_q[2].dx >= 9'(j * CELL_ADVANCE)) begin
        s_d[3].ci = 4'(j);
        cbase     = 9'(j * CELL_ADVANCE);
      end
    end
    s_d[3].cx     = 5'(s_q[2].dx - cbase);
    st            = dec_step(20'(s_q[2].txr), 20'd10);
    s_d[3].txd[1] = st[23:20];
    s_d[3].txd[0] = st[3:0];
    st2           = dec_step(20'(s_q[2].tyr), 20'd10);
    s_d[3].tyd[1] = st2[23:20];
    s_d[3].tyd[0] = st2[3:0];

    // Stage 4: uptime ten-thousands, dot column and row
    s_d[4]        = s_q[3];
    st            = dec_step(s_q[3].urem, 20'd10000);
    s_d[4].ud[4]  = st[23:20];
    s_d[4].urem   = st[19:0];
    s_d[4].col    = 3'(s_q[3].cx >> $clog2(DOT_SCALE));
    s_d[4].row    = 3'(s_q[3].r >> $clog2(DOT_SCALE));
    s_d[4].dot_ok = s_q[3].in_line && (s_q[3].cx < 5'(DOT_COLS * DOT_SCALE));

    // Stages 5 to 7: remaining uptime digits
    s_d[5]       = s_q[4];
    st           = dec_step(s_q[4].urem, 20'd1000);
    s_d[5].ud[3] = st[23:20];
    s_d[5].urem  = st[19:0];

    s_d[6]       = s_q[5];
    st           = dec_step(s_q[5].urem, 20'd100);
    s_d[6].ud[2] = st[23:20];
    s_d[6].urem  = st[19:0];

    s_d[7]       = s_q[6];
    st           = dec_step(s_q[6].urem, 20'd10);
    s_d[7].ud[1] = st[23:20];
    s_d[7].ud[0] = st[3:0];
    s_d[7].urem  = st[19:0];

    // Stage 8: glyph code of the addressed character
    s_d[8]      = s_q[7];
    s_d[8].code = cell_code(s_q[7].line, s_q[7].ci, s_q[7].tv, s_q[7].ud,
                            s_q[7].txd, s_q[7].tyd);

    // Output stage: font lookup and color select
    dot = s_q[8].dot_ok && glyph_dot(s_q[8].code, s_q[8].col, s_q[8].row);
    if (!s_q[8].in_panel) begin
      color_d = bg_q;
    end else if (dot) begin
      color_d = (s_q[8].line == LINE_TITLE || s_q[8].line == LINE_UPTIME) ? text_q
                                                                          : accent_q;
    end else begin
      color_d = panel_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) s_q[i] <= s_d[i];
    end
    if (rdy[NST]) color_q <= color_d;
  end

  assign out_valid_o   = v_q[NST];
  assign pixel_color_o = color_q;

  // Checks
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) ==
      $countones($past(v_q)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("transaction lost or duplicated in pipeline");

  a_uptime_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (s_q[2].urem < 20'(UPTIME_MOD)))
    else $error("uptime remainder out of range");

  a_glyph_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[8] |-> (s_q[8].code < 6'(NUM_GLYPHS)))
    else $error("glyph code out of range");

endmodule

`default_nettype wire

// ===== bench/panel_color_checker.sv =====
// Checker for the status panel generator: predicts every pixel color and compares the results.
module panel_color_checker import tppg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  input  logic [31:0] uptime_sec_i,
  input  logic        touch_valid_i,
  input  logic [15:0] touch_x_i,
  input  logic [15:0] touch_y_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] pixel_color_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Panel geometry
  localparam int SCR_W     = 800;
  localparam int SCR_H     = 480;
  localparam int TEXT_W    = 380;
  localparam int TEXT_H    = 316;
  localparam int ORG_X     = (SCR_W - TEXT_W) / 2;
  localparam int ORG_Y     = (SCR_H - TEXT_H) / 2;
  localparam int PAD       = 16;
  localparam int ROW_PITCH = 44;
  localparam int ROW_H     = 28;
  localparam int LINES     = 5;
  localparam int ADV       = 24;
  localparam int DOT       = 4;
  localparam int DOT_W     = 5;

  // Line texts, padded to the longest line; digit cells are filled per pixel
  localparam logic [7:0] TITLE_TXT [16] = '{
    "u", "l", "m", "k", " ", "M", "i", "c", "r", "o", "k", "e", "r", "n", "e", "l"
  };
  localparam logic [7:0] BOARD_TXT [16] = '{
    "H", "e", "l", "l", "o", " ", "L", "i", "n", "u", "m", "!", " ", " ", " ", " "
  };
  localparam logic [7:0] UPTIME_TXT [16] = '{
    "u", "p", "t", "i", "m", "e", ":", " ", "0", "0", "0", "0", "0", "0", " ", "s"
  };

  logic [15:0] bg_color;
  logic [15:0] panel_color;
  logic [15:0] text_color;
  logic [15:0] accent_color;
  logic [15:0] colors_due [$];
  logic [15:0] oldest_color;

  // Color of one pixel under the current register settings
  function automatic logic [15:0] panel_pixel_color(input logic [9:0] px, input logic [8:0] py,
                                                    input logic [31:0] up, input logic tv,
                                                    input logic [15:0] tx, input logic [15:0] ty);
    int x, y, dy, ln, r, len, lx, dx, cx, i;
    logic [7:0]  txt [16];
    logic [31:0] num;
    logic [39:0] cols;
    logic [7:0]  dots;
    x = int'(px);
    y = int'(py);
    if (x < ORG_X - PAD || x >= ORG_X + TEXT_W + PAD ||
        y < ORG_Y - PAD || y >= ORG_Y + TEXT_H + PAD) return bg_color;
    dy = y - ORG_Y;
    if (dy < 0 || dy >= LINES * ROW_PITCH || dy % ROW_PITCH >= ROW_H) return panel_color;
    ln = dy / ROW_PITCH;
    r  = dy % ROW_PITCH;

    // Build the line text
    txt = '{default: " "};
    case (ln)
      0: begin
        txt = TITLE_TXT;
        len = 16;
      end
      1: begin
        txt = BOARD_TXT;
        len = 12;
      end
      2: begin
        txt = UPTIME_TXT;
        num = up % 32'd1000000;
        for (i = 13; i >= 8; i--) begin
          txt[i] = 8'("0" + num % 10);
          num = num / 10;
        end
        len = 16;
      end
      default: begin
        txt[0] = (ln == 3) ? "x" : "y";
        txt[1] = "=";
        if (!tv) begin
          txt[2] = "-";
          txt[3] = "-";
          len = 4;
        end else begin
          num = 32'((ln == 3 ? tx : ty) % 10000);
          for (i = 5; i >= 2; i--) begin
            txt[i] = 8'("0" + num % 10);
            num = num / 10;
          end
          len = 6;
        end
      end
    endcase

    // Locate the character cell and the dot column inside it
    lx = (SCR_W - (len * ADV - DOT)) / 2;
    dx = x - lx;
    if (dx < 0 || dx >= len * ADV) return panel_color;
    cx = dx % ADV;
    if (cx >= DOT_W * DOT) return panel_color;

    // 5x7 font, first dot column in the top byte, bit n is dot row n
    case (txt[dx / ADV])
      "0": cols = 40'h3E5149453E;
      "1": cols = 40'h00427F4000;
      "2": cols = 40'h4261514946;
      "3": cols = 40'h2141454B31;
      "4": cols = 40'h1814127F10;
      "5": cols = 40'h2745454539;
      "6": cols = 40'h3C4A494930;
      "7": cols = 40'h0171090503;
      "8": cols = 40'h3649494936;
      "9": cols = 40'h064949291E;
      "H": cols = 40'h7F0808087F;
      "L": cols = 40'h7F40404040;
      "M": cols = 40'h7F020C027F;
      "c": cols = 40'h3844444420;
      "e": cols = 40'h3854545418;
      "i": cols = 40'h00447D4000;
      "k": cols = 40'h7F10284400;
      "l": cols = 40'h00417F4000;
      "m": cols = 40'h7C04180478;
      "n": cols = 40'h7C08040478;
      "o": cols = 40'h3844444438;
      "p": cols = 40'hFC24242418;
      "r": cols = 40'h7C08040408;
      "s": cols = 40'h4854545424;
      "t": cols = 40'h043F444020;
      "u": cols = 40'h3C4040207C;
      "x": cols = 40'h4428102844;
      "y": cols = 40'h0C5050503C;
      "-": cols = 40'h0808080808;
      ":": cols = 40'h0036360000;
      "!": cols = 40'h00005F0000;
      "=": cols = 40'h1414141414;
      default: cols = '0;
    endcase
    dots = cols[39 - 8 * (cx / DOT) -: 8];
    if (!dots[r / DOT]) return panel_color;
    return (ln == 0 || ln == 2) ? text_color : accent_color;
  endfunction

  // Watch both channels and the register port on every rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      bg_color     = 16'd4294;
      panel_color  = 16'd0;
      text_color   = 16'd65535;
      accent_color = 16'd18015;
      colors_due.delete();
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (colors_due.size() == 0) begin
          $error("pixel_color: result with no pixel outstanding, actual %h", pixel_color_i);
          fail_count_o++;
        end else begin
          oldest_color = colors_due.pop_front();
          if (pixel_color_i !== oldest_color) begin
            $error("pixel_color mismatch: expected %h, actual %h", oldest_color, pixel_color_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        colors_due.push_back(panel_pixel_color(pixel_x_i, pixel_y_i, uptime_sec_i,
                                               touch_valid_i, touch_x_i, touch_y_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_BACKGROUND: bg_color     = cfg_wdata_i;
          CFG_PANEL:      panel_color  = cfg_wdata_i;
          CFG_TEXT:       text_color   = cfg_wdata_i;
          CFG_ACCENT:     accent_color = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o = colors_due.size();
    end
  end

endmodule

// ===== bench/text_panel_pixel_generator_unit_test.sv =====
// Testbench top: drives pixel requests and color settings into the status panel generator.
module text_panel_pixel_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tppg_pkg::*;

  // Rows and columns used to aim random pixels at the text lines
  localparam int AIM_TOP   = 82;
  localparam int AIM_PITCH = 44;
  localparam int AIM_ROWS  = 28;
  localparam int AIM_LEFT  = 206;
  localparam int AIM_RIGHT = 594;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic [9:0]  x;
    logic [8:0]  y;
    logic [31:0] uptime;
    logic        tv;
    logic [15:0] tx;
    logic [15:0] ty;
  } pixel_req_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic [9:0]  pixel_x   = '0;
  logic [8:0]  pixel_y   = '0;
  logic [31:0] uptime    = '0;
  logic        touch_v   = 1'b0;
  logic [15:0] touch_x   = '0;
  logic [15:0] touch_y   = '0;
  logic        out_stall = 1'b1;
  wire         in_stall;
  wire         out_valid;
  wire  [15:0] pixel_color;

  logic tx_idle  = 1'b0;
  logic rx_idle  = 1'b0;
  // count of long hold-offs requested by the stimulus
  int   hold_req = 0;
  int   mismatch_total;
  int   results_due;

  text_panel_pixel_generator_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .uptime_sec_i  (uptime),
    .touch_valid_i (touch_v),
    .touch_x_i     (touch_x),
    .touch_y_i     (touch_y),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_color_o (pixel_color)
  );

  panel_color_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .uptime_sec_i  (uptime),
    .touch_valid_i (touch_v),
    .touch_x_i     (touch_x),
    .touch_y_i     (touch_y),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_color_i (pixel_color),
    .fail_count_o  (mismatch_total),
    .pending_o     (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one pixel transaction, starting and ending at a falling edge
  task automatic send_pixel(input logic [9:0] x, input logic [8:0] y, input logic [31:0] up,
                            input logic tv, input logic [15:0] tx, input logic [15:0] ty);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    uptime   <= up;
    touch_v  <= tv;
    touch_x  <= tx;
    touch_y  <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted color has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  task automatic put_reg(input cfg_idx_e sel, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= sel;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic program_colors(input logic [15:0] bg, input logic [15:0] pn,
                                input logic [15:0] tc, input logic [15:0] ac);
    put_reg(CFG_BACKGROUND, bg);
    put_reg(CFG_PANEL, pn);
    put_reg(CFG_TEXT, tc);
    put_reg(CFG_ACCENT, ac);
    cfg_we <= 1'b0;
  endtask

  // Random pixel: mostly on text rows, some in and around the panel, some anywhere at all
  function automatic pixel_req_t draw_pixel();
    pixel_req_t p;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      p.y = 9'(AIM_TOP + AIM_PITCH * $urandom_range(0, 4) + $urandom_range(0, AIM_ROWS - 1));
      p.x = 10'($urandom_range(AIM_LEFT, AIM_RIGHT));
    end else if (pick < 85) begin
      p.x = 10'($urandom_range(190, 610));
      p.y = 9'($urandom_range(62, 418));
    end else begin
      p.x = 10'($urandom);
      p.y = 9'($urandom);
    end
    case ($urandom_range(0, 3))
      0: p.uptime = $urandom;
      1: p.uptime = $urandom_range(0, 999999);
      2: p.uptime = 32'(1000000 * $urandom_range(0, 4294) + $urandom_range(999990, 1000009));
      default: p.uptime = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
    p.tv = ($urandom_range(0, 3) != 0);
    p.tx = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 9999));
    p.ty = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 9999));
    return p;
  endfunction

  // Color receiver: random hold-offs per result, one long hold on request
  initial begin
    int stall_len;
    int holds_seen;
    holds_seen = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req != holds_seen) begin
        stall_len  = HOLD_LEN;
        holds_seen = hold_req;
      end else begin
        stall_len = rx_idle ? $urandom_range(0, 10) : 0;
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Reset, directed pixels, then random phases under several color settings
  initial begin
    pixel_req_t  p;
    logic [15:0] bg_v, pn_v, tc_v, ac_v;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset colors
    send_pixel(10'd0, 9'd0, 32'd0, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd1023, 9'd511, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    // panel rectangle edges
    send_pixel(10'd194, 9'd66, 32'd5, 1'b1, 16'd1, 16'd2);
    send_pixel(10'd193, 9'd66, 32'd5, 1'b1, 16'd1, 16'd2);
    send_pixel(10'd194, 9'd65, 32'd5, 1'b1, 16'd1, 16'd2);
    send_pixel(10'd605, 9'd413, 32'd5, 1'b1, 16'd1, 16'd2);
    send_pixel(10'd606, 9'd413, 32'd5, 1'b1, 16'd1, 16'd2);
    send_pixel(10'd605, 9'd414, 32'd5, 1'b1, 16'd1, 16'd2);
    // title and board glyph dots
    send_pixel(10'd210, 9'd90, 32'd0, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd258, 9'd126, 32'd0, 1'b0, 16'd0, 16'd0);
    // uptime digits: zero, the largest shown value, and the 32-bit wrap
    send_pixel(10'd402, 9'd174, 32'd0, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd522, 9'd174, 32'd999999, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd522, 9'd174, 32'd1000000, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd426, 9'd178, 32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0);
    // touch lines: dashes without a touch, digits modulo 10000 with one
    send_pixel(10'd402, 9'd226, 32'd0, 1'b0, 16'd1234, 16'd0);
    send_pixel(10'd378, 9'd218, 32'd0, 1'b1, 16'hFFFF, 16'd0);
    send_pixel(10'd378, 9'd262, 32'd0, 1'b1, 16'd9999, 16'd0);
    send_pixel(10'd402, 9'd270, 32'd0, 1'b0, 16'd0, 16'd9999);
    send_pixel(10'd450, 9'd262, 32'd0, 1'b1, 16'd0, 16'd10000);
    // gap column, row gap between lines, blank bottom dot row, margins
    send_pixel(10'd230, 9'd90, 32'd0, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd210, 9'd112, 32'd0, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd210, 9'd109, 32'd0, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd400, 9'd70, 32'd0, 1'b0, 16'd0, 16'd0);
    send_pixel(10'd400, 9'd398, 32'd0, 1'b1, 16'd0, 16'd0);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          bg_v = 16'h0000; pn_v = 16'hFFFF; tc_v = 16'h0000; ac_v = 16'h0001;
        end
        1: begin
          bg_v = 16'hFFFF; pn_v = 16'h0000; tc_v = 16'hFFFF; ac_v = 16'hFFFE;
        end
        default: begin
          bg_v = 16'($urandom); pn_v = 16'($urandom);
          tc_v = 16'($urandom); ac_v = 16'($urandom);
        end
      endcase
      program_colors(bg_v, pn_v, tc_v, ac_v);
      for (int i = 0; i < 285; i++) begin
        if (i % 40 == 0) begin
          tx_idle = (ph != 0) && ($urandom_range(0, 2) != 0);
          rx_idle = (ph != 0) && ($urandom_range(0, 2) != 0);
        end
        // receiver holds off long enough for the pipeline to back up
        if (ph == 2 && i == 100) hold_req++;
        if (ph == 4 && i == 150) drain_results();
        p = draw_pixel();
        send_pixel(p.x, p.y, p.uptime, p.tv, p.tx, p.ty);
      end
      drain_results();
    end

    repeat (20) @(negedge clk);
    if (mismatch_total == 0) begin
      $display("text_panel_pixel_generator_unit_test OK");
    end else begin
      $display("text_panel_pixel_generator_unit_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("text_panel_pixel_generator_unit_test NOT OK");
    $finish;
  end

endmodule
